// ===== src/btm_pkg.sv =====
`timescale 1ns / 1ps

package btm_pkg;

  localparam int unsigned AddrW   = 64;
  localparam int unsigned ThreadW = 8;
  localparam int unsigned SlotW   = 3;
  // slots that the slot field can name
  localparam int MaxWrSlots = 2 ** SlotW;

  typedef enum logic [2:0] {
    FN_INSERT      = 3'd0,
    FN_REMOVE      = 3'd1,
    FN_CLEAR       = 3'd2,
    FN_LOOKUP      = 3'd3,
    FN_ENABLE      = 3'd4,
    FN_DISABLE     = 3'd5,
    FN_ENABLE_ALL  = 3'd6,
    FN_DISABLE_ALL = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_DONE
  } eng_state_e;

  // what the back end has to do with each slot it visits
  typedef struct packed {
    logic    first_only;   // stop at the first selected slot
    logic    sel_free;     // select slots that are not present
    logic    sel_present;  // select slots that are present
    logic    sel_match;    // select slots whose address equals the request
    logic    fill_slot;    // load address, set present and enabled
    logic    zero_slot;    // zero address, present and enabled
    logic    upd_en;       // overwrite enabled flag
    logic    en_val;
    logic    lookup;       // report a hit only, no slot write
    status_e miss_status;
  } cls_t;

  typedef struct packed {
    logic [ThreadW-1:0] thread;
    logic [AddrW-1:0]   addr;
    cls_t               cls;
  } req_t;

  typedef struct packed {
    logic [ThreadW-1:0] thread_out;
    logic               write_valid;
    logic [SlotW-1:0]   slot;
    logic               slot_active;
    logic [AddrW-1:0]   slot_addr;
    logic [1:0]         status;
    logic               hit;
    logic               last;
  } rsp_t;

endpackage

// ===== src/btm_req_if.sv =====
`timescale 1ns / 1ps

interface btm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  thread_sel;
  logic [63:0] bp_addr;

  modport source (output valid, output func, output thread_sel, output bp_addr, input ready);
  modport sink (input valid, input func, input thread_sel, input bp_addr, output ready);
endinterface

// ===== src/btm_rsp_if.sv =====
`timescale 1ns / 1ps

interface btm_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  thread_out;
  logic        write_valid;
  logic [2:0]  slot;
  logic        slot_active;
  logic [63:0] slot_addr;
  logic [1:0]  status;
  logic        hit;
  logic        last;

  modport source (
    output valid, output thread_out, output write_valid, output slot, output slot_active,
    output slot_addr, output status, output hit, output last, input ready
  );
  modport sink (
    input valid, input thread_out, input write_valid, input slot, input slot_active,
    input slot_addr, input status, input hit, input last, output ready
  );
endinterface

// ===== src/btm_front.sv =====
`timescale 1ns / 1ps

module btm_front
  import btm_pkg::*;
(
  btm_req_if.sink req_i,
  input  logic    q_full_i,
  output logic    push_o,
  output req_t    push_data_o
);

  cls_t cls;

  assign req_i.ready = ~q_full_i;
  assign push_o      = req_i.valid & ~q_full_i;

  always_comb begin
    cls = '0;
    cls.miss_status = ST_OK;
    unique case (func_e'(req_i.func)) inside
      FN_INSERT: begin
        cls.first_only  = 1'b1;
        cls.sel_free    = 1'b1;
        cls.fill_slot   = 1'b1;
        cls.miss_status = ST_FULL;
      end
      FN_REMOVE: begin
        // matches on address alone, present or not
        cls.first_only  = 1'b1;
        cls.sel_match   = 1'b1;
        cls.zero_slot   = 1'b1;
        cls.miss_status = ST_NO_MATCH;
      end
      FN_CLEAR: begin
        cls.sel_present = 1'b1;
        cls.zero_slot   = 1'b1;
      end
      FN_LOOKUP: begin
        cls.first_only  = 1'b1;
        cls.sel_present = 1'b1;
        cls.sel_match   = 1'b1;
        cls.lookup      = 1'b1;
      end
      FN_ENABLE, FN_DISABLE: begin
        cls.first_only  = 1'b1;
        cls.sel_present = 1'b1;
        cls.sel_match   = 1'b1;
        cls.upd_en      = 1'b1;
        cls.en_val      = (func_e'(req_i.func) == FN_ENABLE);
        cls.miss_status = ST_NO_MATCH;
      end
      FN_ENABLE_ALL, FN_DISABLE_ALL: begin
        cls.sel_present = 1'b1;
        cls.upd_en      = 1'b1;
        cls.en_val      = (func_e'(req_i.func) == FN_ENABLE_ALL);
      end
      default: cls = '0;
    endcase
  end

  assign push_data_o = '{thread: req_i.thread_sel, addr: req_i.bp_addr, cls: cls};

endmodule

// ===== src/btm_queue.sv =====
`timescale 1ns / 1ps

module btm_queue
  import btm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output req_t head_o
);

  // two entries
  req_t       store_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/btm_engine.sv =====
`timescale 1ns / 1ps

module btm_engine
  import btm_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic head_valid_i,
  input  req_t head_i,
  output logic pop_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(NUM_SLOTS - 1);

  eng_state_e state_q, state_d;

  logic [IdxW-1:0]  idx_q;
  req_t             cur_q;
  status_e          status_q;
  logic             hit_q;
  logic             sent_q;

  logic [AddrW-1:0] mem [NUM_SLOTS];
  logic [AddrW-1:0] rdata_q;
  logic [NUM_SLOTS-1:0] wv_q;    // entry holds a written address
  logic [NUM_SLOTS-1:0] pres_q;
  logic [NUM_SLOTS-1:0] en_q;

  logic             out_vld_q;
  rsp_t             out_q;

  logic [AddrW-1:0] cur_addr;
  logic             cur_p, cur_e, sel, writable, later_p;
  logic             p_new, e_new;
  logic [AddrW-1:0] a_new;
  logic             out_free, emit_wr, stall, advance, end_scan;
  logic             rd_en, mem_we, out_load;
  logic [IdxW-1:0]  rd_addr;
  rsp_t             out_d;

  // slot under evaluation
  assign cur_addr = wv_q[idx_q] ? rdata_q : '0;
  assign cur_p    = pres_q[idx_q];
  assign cur_e    = en_q[idx_q];
  assign sel      = (~cur_q.cls.sel_free    | ~cur_p) &
                    (~cur_q.cls.sel_present |  cur_p) &
                    (~cur_q.cls.sel_match   | (cur_addr == cur_q.addr));
  assign writable = (int'(idx_q) < MaxWrSlots);

  always_comb begin
    p_new = cur_p;
    e_new = cur_e;
    a_new = cur_addr;
    if (cur_q.cls.fill_slot) begin
      p_new = 1'b1;
      e_new = 1'b1;
      a_new = cur_q.addr;
    end else if (cur_q.cls.zero_slot) begin
      p_new = 1'b0;
      e_new = 1'b0;
      a_new = '0;
    end else if (cur_q.cls.upd_en) begin
      e_new = cur_q.cls.en_val;
    end
  end

  // any present slot further on that will still produce a write
  always_comb begin
    later_p = 1'b0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if ((j > int'(idx_q)) && (j < MaxWrSlots)) begin
        later_p = later_p | pres_q[j];
      end
    end
  end

  assign out_free = ~out_vld_q | rsp_ready_i;
  assign emit_wr  = (state_q == ENG_SCAN) & sel & ~cur_q.cls.lookup & writable;
  assign stall    = emit_wr & ~out_free;
  assign advance  = (state_q == ENG_SCAN) & ~stall;
  assign end_scan = (sel & cur_q.cls.first_only) | (idx_q == IdxLast);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ENG_IDLE: begin
        if (head_valid_i) begin
          state_d = ENG_SCAN;
        end
      end
      ENG_SCAN: begin
        if (advance && end_scan) begin
          state_d = ENG_DONE;
        end
      end
      ENG_DONE: begin
        if (sent_q || out_free) begin
          state_d = ENG_IDLE;
        end
      end
      default: state_d = ENG_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    out_d    = '{thread_out: cur_q.thread, write_valid: 1'b0, slot: '0, slot_active: 1'b0,
                 slot_addr: '0, status: status_q, hit: hit_q, last: 1'b1};
    unique case (state_q)
      ENG_IDLE: begin
        pop_o = head_valid_i;
        rd_en = head_valid_i;
      end
      ENG_SCAN: begin
        rd_en    = advance & ~end_scan;
        rd_addr  = idx_q + IdxW'(1);
        mem_we   = advance & sel & cur_q.cls.fill_slot;
        out_load = emit_wr & out_free;
        out_d    = '{thread_out: cur_q.thread, write_valid: 1'b1, slot: SlotW'(idx_q),
                     slot_active: p_new & e_new, slot_addr: a_new, status: ST_OK, hit: 1'b0,
                     last: cur_q.cls.first_only | ~later_p};
      end
      ENG_DONE: begin
        out_load = ~sent_q & out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ENG_IDLE;
      idx_q    <= '0;
      status_q <= ST_OK;
      hit_q    <= 1'b0;
      sent_q   <= 1'b0;
      wv_q     <= '0;
      pres_q   <= '0;
      en_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        idx_q    <= '0;
        status_q <= head_i.cls.miss_status;
        hit_q    <= 1'b0;
        sent_q   <= 1'b0;
      end else if (advance) begin
        if (!end_scan) begin
          idx_q <= idx_q + IdxW'(1);
        end
        if (sel) begin
          status_q      <= ST_OK;
          hit_q         <= hit_q | cur_q.cls.lookup;
          pres_q[idx_q] <= p_new;
          en_q[idx_q]   <= e_new;
          if (cur_q.cls.fill_slot) begin
            wv_q[idx_q] <= 1'b1;
          end else if (cur_q.cls.zero_slot) begin
            wv_q[idx_q] <= 1'b0;
          end
        end
        if (emit_wr) begin
          sent_q <= 1'b1;
        end
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx_q] <= cur_q.addr;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign rsp_valid_o = out_vld_q;
  assign rsp_o       = out_q;

endmodule

// ===== src/breakpoint_table_manager.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake      word
// req_i     in   valid/ready    func, thread_sel, bp_addr
// rsp_o     out  valid/ready    thread_out, write_valid, slot, slot_active, slot_addr,
//                               status, hit, last
//
// a request is taken into a two-word queue in the cycle it arrives if the queue has room; the
// engine pops it, walks the slot table one slot a cycle (unless a full output register stalls
// it) through the address memory's registered read port and stops at the first selected slot
// for single-slot operations
// reset clears the queue, the engine and all slot flags; addresses never written read as zero
// the output register holds a result until taken, and the engine stalls only when it has a
// further result to post while that register is still full

module breakpoint_table_manager
  import btm_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  btm_req_if.sink   req_i,
  btm_rsp_if.source rsp_o
);

  // front to queue
  logic push;
  req_t push_data;
  logic q_full;

  // queue to engine
  logic head_valid;
  req_t head;
  logic pop;

  // engine output register
  rsp_t rsp;
  logic rsp_valid;

  // decode the operation into per-slot actions
  btm_front u_front (
    .req_i       (req_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decouples request intake from the table walk
  btm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // table storage and the slot walk
  btm_engine #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .rsp_valid_o  (rsp_valid),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_o        (rsp)
  );

  assign rsp_o.valid       = rsp_valid;
  assign rsp_o.thread_out  = rsp.thread_out;
  assign rsp_o.write_valid = rsp.write_valid;
  assign rsp_o.slot        = rsp.slot;
  assign rsp_o.slot_active = rsp.slot_active;
  assign rsp_o.slot_addr   = rsp.slot_addr;
  assign rsp_o.status      = rsp.status;
  assign rsp_o.hit         = rsp.hit;
  assign rsp_o.last        = rsp.last;

endmodule

// ===== bench/tb_breakpoint_table_manager.sv =====
`timescale 1ns / 1ps

module tb_breakpoint_table_manager;
  import btm_pkg::*;

  localparam int NSLOTS     = 8;
  localparam int IDLE_LIMIT = 2000;  // cycles with no word moving on either channel
  localparam int RAND_REQS  = 143;
  localparam int DRAIN_CYC  = 24;

  // one request word plus the number of cycles the sender idles before it
  typedef struct {
    func_e       fn;
    logic [7:0]  thr;
    logic [63:0] addr;
    int          gap;
  } req_word_t;

  logic clk_i;
  logic rst_ni;

  btm_req_if req_bus ();
  btm_rsp_if rsp_bus ();

  breakpoint_table_manager #(
    .NUM_SLOTS(NSLOTS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  // shadow of the breakpoint table
  logic [63:0] tbl_addr[NSLOTS];
  logic        tbl_present[NSLOTS];
  logic        tbl_enabled[NSLOTS];

  req_word_t req_backlog[$];  // requests still to be driven
  rsp_t      due_words[$];    // result words still to arrive, oldest first
  logic [63:0] addr_pool[$];  // recently inserted addresses, reused to hit the table

  req_word_t cur_req;
  bit        cur_loaded;
  bit        req_fire;
  bit        rsp_fire;
  bit        send_calm;
  bit        recv_calm;
  int        recv_stall;
  int        recv_taken;
  int        idle_cycles;
  int        fault_cnt;

  always #6 clk_i = ~clk_i;

  // idle time for one word: none at all inside a calm stretch
  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 18));
  endfunction

  task automatic post(input func_e fn, input logic [7:0] thr, input logic [63:0] addr);
    req_word_t w;
    if (req_backlog.size() % 20 == 0) send_calm = ($urandom_range(0, 3) == 0);
    w.fn   = fn;
    w.thr  = thr;
    w.addr = addr;
    w.gap  = draw_wait(send_calm);
    req_backlog.push_back(w);
  endtask

  // queue a slot register write for slot i as it stands now
  task automatic note_slot_write(input logic [7:0] thr, input int i, inout int n);
    rsp_t w;
    if (i >= MaxWrSlots) return;
    w.thread_out  = thr;
    w.write_valid = 1'b1;
    w.slot        = i[SlotW-1:0];
    w.slot_active = tbl_enabled[i] & tbl_present[i];
    w.slot_addr   = tbl_addr[i];
    w.status      = ST_OK;
    w.hit         = 1'b0;
    w.last        = 1'b0;
    due_words.push_back(w);
    n++;
  endtask

  // apply one accepted request to the shadow table and queue the words it causes
  task automatic apply_to_table(input func_e fn, input logic [7:0] thr, input logic [63:0] a);
    rsp_t    w;
    int      n;
    status_e st;
    logic    hit;
    n   = 0;
    st  = ST_OK;
    hit = 1'b0;
    case (fn) inside
      FN_INSERT: begin
        st = ST_FULL;
        for (int i = 0; i < NSLOTS; i++) begin
          if (!tbl_present[i]) begin
            tbl_addr[i]    = a;
            tbl_present[i] = 1'b1;
            tbl_enabled[i] = 1'b1;
            note_slot_write(thr, i, n);
            st = ST_OK;
            break;
          end
        end
      end
      FN_REMOVE: begin
        // matches on address alone, so a freed slot holding zero can be hit
        st = ST_NO_MATCH;
        for (int i = 0; i < NSLOTS; i++) begin
          if (tbl_addr[i] == a) begin
            tbl_addr[i]    = '0;
            tbl_present[i] = 1'b0;
            tbl_enabled[i] = 1'b0;
            note_slot_write(thr, i, n);
            st = ST_OK;
            break;
          end
        end
      end
      FN_CLEAR: begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (tbl_present[i]) begin
            tbl_addr[i]    = '0;
            tbl_present[i] = 1'b0;
            tbl_enabled[i] = 1'b0;
            note_slot_write(thr, i, n);
          end
        end
      end
      FN_LOOKUP: begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (tbl_present[i] && tbl_addr[i] == a) begin
            hit = 1'b1;
            break;
          end
        end
      end
      FN_ENABLE, FN_DISABLE: begin
        st = ST_NO_MATCH;
        for (int i = 0; i < NSLOTS; i++) begin
          if (tbl_present[i] && tbl_addr[i] == a) begin
            tbl_enabled[i] = (fn == FN_ENABLE);
            note_slot_write(thr, i, n);
            st = ST_OK;
            break;
          end
        end
      end
      default: begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (tbl_present[i]) begin
            tbl_enabled[i] = (fn == FN_ENABLE_ALL);
            note_slot_write(thr, i, n);
          end
        end
      end
    endcase
    // nothing changed: a single status-only word
    if (n == 0) begin
      w             = '0;
      w.thread_out  = thr;
      w.status      = st;
      w.hit         = hit;
      due_words.push_back(w);
    end
    due_words[due_words.size() - 1].last = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fault_cnt++;
    end
  endtask

  // request driver: payload changes on the falling edge, held until taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else if (req_bus.valid && !req_fire) begin
      // word still waiting for ready
    end else begin
      if (!cur_loaded && req_backlog.size() > 0) begin
        cur_req    = req_backlog.pop_front();
        cur_loaded = 1'b1;
      end
      if (cur_loaded && cur_req.gap == 0) begin
        req_bus.valid      <= 1'b1;
        req_bus.func       <= cur_req.fn;
        req_bus.thread_sel <= cur_req.thr;
        req_bus.bp_addr    <= cur_req.addr;
        cur_loaded = 1'b0;
      end else begin
        req_bus.valid <= 1'b0;
        if (cur_loaded) cur_req.gap--;
      end
    end
  end

  // result sink: a fresh stall is drawn after every word taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_fire) begin
        if (recv_taken % 24 == 0) recv_calm = ($urandom_range(0, 3) == 0);
        recv_stall = draw_wait(recv_calm);
      end
      if (recv_stall > 0) begin
        rsp_bus.ready <= 1'b0;
        recv_stall--;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // sample both channels on the rising edge; results are checked before the
  // request of the same edge is applied, since it cannot answer itself
  always @(posedge clk_i) begin
    rsp_t want_w;
    req_fire <= rst_ni && req_bus.valid && req_bus.ready;
    rsp_fire <= rst_ni && rsp_bus.valid && rsp_bus.ready;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      recv_taken++;
      if (due_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %p", $time, rsp_bus.slot_addr);
        fault_cnt++;
      end else begin
        want_w = due_words.pop_front();
        check_field("thread_out", 64'(want_w.thread_out), 64'(rsp_bus.thread_out));
        check_field("write_valid", 64'(want_w.write_valid), 64'(rsp_bus.write_valid));
        check_field("slot", 64'(want_w.slot), 64'(rsp_bus.slot));
        check_field("slot_active", 64'(want_w.slot_active), 64'(rsp_bus.slot_active));
        check_field("slot_addr", want_w.slot_addr, rsp_bus.slot_addr);
        check_field("status", 64'(want_w.status), 64'(rsp_bus.status));
        check_field("hit", 64'(want_w.hit), 64'(rsp_bus.hit));
        check_field("last", 64'(want_w.last), 64'(rsp_bus.last));
      end
    end
    if (rst_ni && req_bus.valid && req_bus.ready)
      apply_to_table(func_e'(req_bus.func), req_bus.thread_sel, req_bus.bp_addr);
  end

  // watchdog on a stuck handshake
  always @(posedge clk_i) begin
    if (!rst_ni || req_fire || rsp_fire) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int          r;
    logic [63:0] a;
    func_e       fn;

    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.func       = FN_LOOKUP;
    req_bus.thread_sel = '0;
    req_bus.bp_addr    = '0;
    rsp_bus.ready      = 1'b0;
    cur_loaded         = 1'b0;
    req_fire           = 1'b0;
    rsp_fire           = 1'b0;
    send_calm          = 1'b0;
    recv_calm          = 1'b0;
    recv_stall         = 0;
    recv_taken         = 0;
    idle_cycles        = 0;
    fault_cnt          = 0;
    for (int i = 0; i < NSLOTS; i++) begin
      tbl_addr[i]    = '0;
      tbl_present[i] = 1'b0;
      tbl_enabled[i] = 1'b0;
    end

    // empty table: misses, remove of a zero address hitting a free slot,
    // bulk operations with nothing to touch
    post(FN_LOOKUP, 8'h00, 64'h0);
    post(FN_REMOVE, 8'hFF, 64'h1234);
    post(FN_REMOVE, 8'h5A, 64'h0);
    post(FN_ENABLE, 8'hA5, 64'h0);
    post(FN_DISABLE, 8'h01, 64'h0);
    post(FN_CLEAR, 8'h80, 64'h0);
    post(FN_ENABLE_ALL, 8'h7F, 64'hFFFF_FFFF_FFFF_FFFF);
    post(FN_DISABLE_ALL, 8'hFF, 64'h0);
    // fill every slot with extreme addresses, then one insert too many
    post(FN_INSERT, 8'h00, 64'h0);
    post(FN_INSERT, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    post(FN_INSERT, 8'($urandom), 64'h1);
    post(FN_INSERT, 8'($urandom), 64'h8000_0000_0000_0000);
    post(FN_INSERT, 8'($urandom), 64'h5555_5555_5555_5555);
    post(FN_INSERT, 8'($urandom), 64'hAAAA_AAAA_AAAA_AAAA);
    post(FN_INSERT, 8'($urandom), 64'h0123_4567_89AB_CDEF);
    post(FN_INSERT, 8'($urandom), 64'hFEDC_BA98_7654_3210);
    post(FN_INSERT, 8'hFF, 64'hDEAD);
    // lookups, single and bulk flag updates on a full table
    post(FN_LOOKUP, 8'h3C, 64'hFFFF_FFFF_FFFF_FFFF);
    post(FN_LOOKUP, 8'hC3, 64'hDEAD);
    post(FN_DISABLE, 8'($urandom), 64'h1);
    post(FN_ENABLE, 8'($urandom), 64'h1);
    post(FN_DISABLE_ALL, 8'($urandom), 64'h0);
    post(FN_ENABLE_ALL, 8'($urandom), 64'h0);
    // free a middle slot, refill it, then empty the table
    post(FN_REMOVE, 8'($urandom), 64'h5555_5555_5555_5555);
    post(FN_INSERT, 8'($urandom), 64'hDEAD);
    post(FN_CLEAR, 8'($urandom), 64'h0);
    post(FN_REMOVE, 8'($urandom), 64'h0);

    // random traffic, biased towards addresses already in the table
    for (int k = 0; k < RAND_REQS; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30)      fn = FN_INSERT;
      else if (r < 42) fn = FN_REMOVE;
      else if (r < 55) fn = FN_LOOKUP;
      else if (r < 67) fn = FN_ENABLE;
      else if (r < 79) fn = FN_DISABLE;
      else if (r < 85) fn = FN_CLEAR;
      else if (r < 93) fn = FN_ENABLE_ALL;
      else             fn = FN_DISABLE_ALL;
      r = $urandom_range(0, 9);
      if (r < 5 && addr_pool.size() > 0)
        a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
      else if (r == 5)
        a = '0;
      else if (r == 6)
        a = '1;
      else
        a = {$urandom, $urandom};
      if (fn == FN_INSERT) begin
        addr_pool.push_back(a);
        if (addr_pool.size() > 16) void'(addr_pool.pop_front());
      end
      post(fn, 8'($urandom), a);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all requests taken, then all words back, then a margin for strays
    while (req_backlog.size() != 0 || cur_loaded || req_bus.valid) @(negedge clk_i);
    while (due_words.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);

    if (fault_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/btm_pkg.sv
src/btm_req_if.sv
src/btm_rsp_if.sv
src/btm_front.sv
src/btm_queue.sv
src/btm_engine.sv
src/breakpoint_table_manager.sv
bench/tb_breakpoint_table_manager.sv
